FILE: design/complex_accumulator_alu_top_assert.svh
// Assertion macros shared by the complex accumulator modules.
`ifndef COMPLEX_ACCUMULATOR_ALU_TOP_ASSERT_SVH
`define COMPLEX_ACCUMULATOR_ALU_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CAI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CAI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cai_pkg.sv
// Shared types, codes and the product microcode of the complex accumulator.
package cai_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_MAG  = 3'd4;
  localparam logic [2:0] OP_LOAD = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [3:0] STEP_MUL      = 4'd0;
  localparam logic [3:0] STEP_DIV      = 4'd4;
  localparam logic [3:0] STEP_MAG      = 4'd10;
  localparam logic [3:0] STEP_MAG_LAST = 4'd11;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [DATA_W-1:0] operand_real;
    logic signed [DATA_W-1:0] operand_imag;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc_real_out;
    logic signed [DATA_W-1:0] acc_imag_out;
    logic [DATA_W-1:0]        magnitude;
    logic [1:0]               status;
  } rsp_t;

  typedef enum logic [1:0] {SEL_AR, SEL_AI, SEL_CR, SEL_CI} sel_t;
  typedef enum logic [1:0] {DST_T0, DST_T1, DST_T2} dst_t;

  typedef struct packed {
    sel_t a;
    sel_t b;
    dst_t dst;
    logic neg;
    logic clr;
    logic last;
  } uop_t;

  typedef struct packed {
    logic load_req;
    logic alu_upd;
    logic prod;
    logic acc_p;
    uop_t uop;
    logic mul_fin;
    logic iter_start;
    logic iter_sqrt;
    logic div_im;
    logic wr_div;
    logic wr_mag;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       div_zero;
    logic       iter_done;
  } sts_t;

  // One product per step: a times b, added to or subtracted from a temporary.
  function automatic uop_t uop_at(input logic [3:0] step);
    uop_t u;
    u = '{a: SEL_AI, b: SEL_AI, dst: DST_T2, neg: 1'b0, clr: 1'b0, last: 1'b1};
    case (step)
      4'd0:  u = '{SEL_AR, SEL_CR, DST_T0, 1'b0, 1'b1, 1'b0};
      4'd1:  u = '{SEL_AI, SEL_CI, DST_T0, 1'b1, 1'b0, 1'b0};
      4'd2:  u = '{SEL_AI, SEL_CR, DST_T1, 1'b0, 1'b1, 1'b0};
      4'd3:  u = '{SEL_AR, SEL_CI, DST_T1, 1'b0, 1'b0, 1'b1};
      4'd4:  u = '{SEL_CR, SEL_CR, DST_T2, 1'b0, 1'b1, 1'b0};
      4'd5:  u = '{SEL_CI, SEL_CI, DST_T2, 1'b0, 1'b0, 1'b0};
      4'd6:  u = '{SEL_AR, SEL_CR, DST_T0, 1'b0, 1'b1, 1'b0};
      4'd7:  u = '{SEL_AI, SEL_CI, DST_T0, 1'b0, 1'b0, 1'b0};
      4'd8:  u = '{SEL_AI, SEL_CR, DST_T1, 1'b0, 1'b1, 1'b0};
      4'd9:  u = '{SEL_AR, SEL_CI, DST_T1, 1'b1, 1'b0, 1'b1};
      4'd10: u = '{SEL_AR, SEL_AR, DST_T2, 1'b0, 1'b1, 1'b0};
      4'd11: u = '{SEL_AI, SEL_AI, DST_T2, 1'b0, 1'b0, 1'b1};
      default: u = '{SEL_AI, SEL_AI, DST_T2, 1'b0, 1'b0, 1'b1};
    endcase
    return u;
  endfunction

endpackage

FILE: design/cai_iter.sv
// Shared bit-serial unit: restoring division and digit-by-digit square root.
`include "complex_accumulator_alu_top_assert.svh"
module cai_iter import cai_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            sqrt_mode,
  input  logic [2*DATA_W+FRAC_BITS-1:0]   src,
  input  logic [2*DATA_W-1:0]             den,
  output logic                            done,
  output logic [2*DATA_W+FRAC_BITS-1:0]   quo
);
  localparam int DW    = DATA_W;
  localparam int NUM_W = 2*DW + FRAC_BITS;
  localparam int REM_W = 2*DW + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic               busy_r, done_r, sqrt_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NUM_W-1:0]   src_r, q_r;
  logic [2*DW-1:0]    den_r;
  logic [REM_W-1:0]   rem_r, rem_sh, trial;
  logic [REM_W:0]     diff;
  logic               ge;
  logic [CNT_W-1:0]   last_cnt;

  // A square root step takes two radicand bits, a division step one.
  always_comb begin
    if (sqrt_r) begin
      rem_sh = {rem_r[REM_W-3:0], src_r[NUM_W-1 -: 2]};
      trial  = {q_r[REM_W-3:0], 2'b01};
      last_cnt = CNT_W'(DW);
    end else begin
      rem_sh = {rem_r[REM_W-2:0], src_r[NUM_W-1]};
      trial  = {1'b0, den_r};
      last_cnt = CNT_W'(NUM_W);
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == last_cnt - CNT_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= '0;
      rem_r  <= '0;
      q_r    <= '0;
      src_r  <= src;
      den_r  <= den;
      sqrt_r <= sqrt_mode;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      rem_r <= ge ? diff[REM_W-1:0] : rem_sh;
      q_r   <= {q_r[NUM_W-2:0], ge};
      src_r <= sqrt_r ? (src_r << 2) : (src_r << 1);
    end
  end

  assign done = done_r;
  assign quo  = q_r;

  `CAI_ASSERT_NXT(a_start_busy, start, busy_r, "iterative unit did not start")
  `CAI_ASSERT_IMP(a_done_idle, done_r, !busy_r, "done raised while still busy")
endmodule

FILE: design/cai_dp.sv
// Datapath: accumulator, operand and temporary registers, multiplier, output register.
module cai_dp import cai_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  req_t in_req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t out_rsp
);
  localparam int DW    = DATA_W;
  localparam int PW    = 2*DW + 2;
  localparam int NUM_W = 2*DW + FRAC_BITS;
  localparam int SW    = NUM_W + 2;
  localparam logic signed [SW-1:0] MAXV = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  function automatic logic [DW:0] sat(input logic signed [SW-1:0] v);
    logic [DW:0] r;
    if (v > MAXV) r = {1'b1, MAXV[DW-1:0]};
    else if (v < MINV) r = {1'b1, MINV[DW-1:0]};
    else r = {1'b0, v[DW-1:0]};
    return r;
  endfunction

  logic [2:0]               op_r;
  logic signed [DW-1:0]     cr_r, ci_r, ar_r, ai_r;
  logic signed [PW-1:0]     t0_r, t1_r, t2_r;
  logic signed [2*DW-1:0]   p_r;
  logic                     clip_r, divz_r;
  logic [DW-1:0]            mag_r;
  rsp_t                     rsp_r;

  logic signed [DW-1:0]     opa, opb;
  logic signed [2*DW-1:0]   prod;
  logic signed [PW-1:0]     pe, base, tsum;
  logic signed [DW:0]       sa_re, sa_im;
  logic [DW:0]              s_re, s_im;
  logic signed [PW-1:0]     sh_re, sh_im, num, absn;
  logic signed [SW-1:0]     qs;
  logic [DW:0]              s_q;
  logic                     it_done;
  logic [NUM_W-1:0]         it_src, it_quo;

  function automatic logic signed [DW-1:0] pick(input sel_t s, input logic signed [DW-1:0] ar,
      input logic signed [DW-1:0] ai, input logic signed [DW-1:0] cr,
      input logic signed [DW-1:0] ci);
    logic signed [DW-1:0] r;
    case (s)
      SEL_AR:  r = ar;
      SEL_AI:  r = ai;
      SEL_CR:  r = cr;
      SEL_CI:  r = ci;
      default: r = ar;
    endcase
    return r;
  endfunction

  always_comb begin
    opa  = pick(cmd.uop.a, ar_r, ai_r, cr_r, ci_r);
    opb  = pick(cmd.uop.b, ar_r, ai_r, cr_r, ci_r);
    prod = opa * opb;
    pe   = {{2{p_r[2*DW-1]}}, p_r};
    case (cmd.uop.dst)
      DST_T0:  base = t0_r;
      DST_T1:  base = t1_r;
      DST_T2:  base = t2_r;
      default: base = t2_r;
    endcase
    if (cmd.uop.clr) base = '0;
    tsum = cmd.uop.neg ? base - pe : base + pe;

    if (op_r == OP_SUB) begin
      sa_re = {ar_r[DW-1], ar_r} - {cr_r[DW-1], cr_r};
      sa_im = {ai_r[DW-1], ai_r} - {ci_r[DW-1], ci_r};
    end else begin
      sa_re = {ar_r[DW-1], ar_r} + {cr_r[DW-1], cr_r};
      sa_im = {ai_r[DW-1], ai_r} + {ci_r[DW-1], ci_r};
    end

    sh_re = t0_r >>> FRAC_BITS;
    sh_im = t1_r >>> FRAC_BITS;
    if (cmd.mul_fin) begin
      s_re = sat({{(SW-PW){sh_re[PW-1]}}, sh_re});
      s_im = sat({{(SW-PW){sh_im[PW-1]}}, sh_im});
    end else begin
      s_re = sat({{(SW-DW-1){sa_re[DW]}}, sa_re});
      s_im = sat({{(SW-DW-1){sa_im[DW]}}, sa_im});
    end

    num  = cmd.div_im ? t1_r : t0_r;
    absn = num[PW-1] ? -num : num;
    it_src = cmd.iter_sqrt ? {t2_r[2*DW-1:0], {FRAC_BITS{1'b0}}}
                           : {absn[2*DW-1:0], {FRAC_BITS{1'b0}}};
    qs  = {2'b00, it_quo};
    if (num[PW-1]) qs = -qs;
    s_q = sat(qs);
  end

  cai_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.iter_start),
    .sqrt_mode (cmd.iter_sqrt),
    .src       (it_src),
    .den       (t2_r[2*DW-1:0]),
    .done      (it_done),
    .quo       (it_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ar_r <= '0;
      ai_r <= '0;
    end else if (cmd.alu_upd) begin
      case (op_r)
        OP_ADD, OP_SUB: begin
          ar_r <= s_re[DW-1:0];
          ai_r <= s_im[DW-1:0];
        end
        OP_LOAD: begin
          ar_r <= cr_r;
          ai_r <= ci_r;
        end
        default: begin
        end
      endcase
    end else if (cmd.mul_fin) begin
      ar_r <= s_re[DW-1:0];
      ai_r <= s_im[DW-1:0];
    end else if (cmd.wr_div && !cmd.div_im) begin
      ar_r <= s_q[DW-1:0];
    end else if (cmd.wr_div) begin
      ai_r <= s_q[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
      divz_r <= 1'b0;
    end else if (cmd.load_req) begin
      clip_r <= 1'b0;
      divz_r <= 1'b0;
    end else if (cmd.alu_upd) begin
      clip_r <= (op_r == OP_ADD || op_r == OP_SUB) && (s_re[DW] || s_im[DW]);
      divz_r <= (op_r == OP_DIV);
    end else if (cmd.mul_fin) begin
      clip_r <= s_re[DW] || s_im[DW];
    end else if (cmd.wr_div) begin
      clip_r <= clip_r || s_q[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r <= in_req.req_type;
      cr_r <= in_req.operand_real;
      ci_r <= in_req.operand_imag;
    end
    if (cmd.prod) p_r <= prod;
    if (cmd.acc_p) begin
      case (cmd.uop.dst)
        DST_T0:  t0_r <= tsum;
        DST_T1:  t1_r <= tsum;
        default: t2_r <= tsum;
      endcase
    end
    if (cmd.wr_mag) mag_r <= it_quo[DW-1:0];
    if (cmd.out_load) begin
      rsp_r.acc_real_out <= ar_r;
      rsp_r.acc_imag_out <= ai_r;
      rsp_r.magnitude    <= mag_r;
      rsp_r.status       <= clip_r ? ST_SAT : (divz_r ? ST_DIVZ : ST_OK);
    end
  end

  assign sts.op        = op_r;
  assign sts.div_zero  = (cr_r == '0) && (ci_r == '0);
  assign sts.iter_done = it_done;
  assign out_rsp       = rsp_r;
endmodule

FILE: design/cai_ctrl.sv
// Controller: sequences each request through products, division, square root and output.
`include "complex_accumulator_alu_top_assert.svh"
module cai_ctrl import cai_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_ALU  = 12'b000000000010,
    S_PMUL = 12'b000000000100,
    S_PACC = 12'b000000001000,
    S_MFIN = 12'b000000010000,
    S_DRS  = 12'b000000100000,
    S_DRW  = 12'b000001000000,
    S_DIS  = 12'b000010000000,
    S_DIW  = 12'b000100000000,
    S_SQS  = 12'b001000000000,
    S_SQW  = 12'b010000000000,
    S_PUSH = 12'b100000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.uop   = uop_at(step_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_ALU;
        end
      end
      S_ALU: begin
        state_nxt = S_PMUL;
        if (sts.op == OP_MUL) begin
          step_nxt = STEP_MUL;
        end else if (sts.op == OP_DIV && !sts.div_zero) begin
          step_nxt = STEP_DIV;
        end else begin
          cmd.alu_upd = 1'b1;
          step_nxt    = STEP_MAG;
        end
      end
      S_PMUL: begin
        cmd.prod  = 1'b1;
        state_nxt = S_PACC;
      end
      S_PACC: begin
        cmd.acc_p = 1'b1;
        if (!cmd.uop.last) begin
          step_nxt  = step_r + 4'd1;
          state_nxt = S_PMUL;
        end else if (step_r == STEP_MAG_LAST) begin
          state_nxt = S_SQS;
        end else if (sts.op == OP_MUL) begin
          state_nxt = S_MFIN;
        end else begin
          state_nxt = S_DRS;
        end
      end
      S_MFIN: begin
        cmd.mul_fin = 1'b1;
        step_nxt    = STEP_MAG;
        state_nxt   = S_PMUL;
      end
      S_DRS: begin
        cmd.iter_start = 1'b1;
        state_nxt      = S_DRW;
      end
      S_DRW: begin
        if (sts.iter_done) begin
          cmd.wr_div = 1'b1;
          state_nxt  = S_DIS;
        end
      end
      S_DIS: begin
        cmd.div_im     = 1'b1;
        cmd.iter_start = 1'b1;
        state_nxt      = S_DIW;
      end
      S_DIW: begin
        cmd.div_im = 1'b1;
        if (sts.iter_done) begin
          cmd.wr_div = 1'b1;
          step_nxt   = STEP_MAG;
          state_nxt  = S_PMUL;
        end
      end
      S_SQS: begin
        cmd.iter_sqrt  = 1'b1;
        cmd.iter_start = 1'b1;
        state_nxt      = S_SQW;
      end
      S_SQW: begin
        cmd.iter_sqrt = 1'b1;
        if (sts.iter_done) begin
          cmd.wr_mag = 1'b1;
          state_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_MAG;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `CAI_ASSERT_NXT(a_accept_alu, in_valid && in_ready, state_r == S_ALU,
                  "accepted request did not enter the ALU step")
  `CAI_ASSERT_NXT(a_push_out, state_r == S_PUSH && out_free, out_valid_r && state_r == S_IDLE,
                  "finished result was not presented")
  `CAI_ASSERT_IMP(a_done_wait, sts.iter_done,
                  state_r == S_DRW || state_r == S_DIW || state_r == S_SQW,
                  "iterative unit finished outside a wait state")
endmodule

FILE: design/complex_accumulator_alu_top.sv
// Top level of the complex accumulator arithmetic unit.
// Complex accumulator ALU. The block holds one complex accumulator (signed
// fixed point, DATA_W bits per part with FRAC_BITS fractional bits, Q15.16 by
// default) that resets to zero. Each request names an operation (add,
// subtract, multiply, divide, magnitude only, load) and carries a complex
// operand; each request returns exactly one result with the new accumulator,
// its magnitude (floor of the exact square root of re^2 + im^2, unsigned with
// FRAC_BITS fractional bits) and a status code: saturated when a part had to
// be clipped, divide by zero when a 0 + 0i divisor left the accumulator as it
// was. Unused request codes behave like magnitude only. The block works on
// one request at a time: all products come from a single registered
// multiplier, and the divisions and the square root share one bit-serial
// unit that resolves one quotient bit or one root bit per cycle. The result
// sits in an output register; the next request is taken while it waits, and
// only the final hand-over waits for the output side to drain.
module complex_accumulator_alu_top import cai_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);
  cmd_t cmd;
  sts_t sts;

  // Controller: sequences each request and owns the handshakes.
  cai_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: accumulator, multiplier, shared iterative unit, result register.
  cai_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );
endmodule

FILE: bench/tb_complex_accumulator_alu_top.sv
// Testbench for the complex accumulator ALU: random and directed requests checked against a predictor.
module tb_complex_accumulator_alu_top;
  import cai_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  rsp_t out_rsp;

  complex_accumulator_alu_top #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
  );

  // Predictor state: the accumulator as this bench believes it to be.
  logic signed [DATA_W-1:0] model_re;
  logic signed [DATA_W-1:0] model_im;

  // Results still owed by the block, oldest first.
  rsp_t pending_rsp[$];
  int errors;
  int sender_idle_pct;
  int receiver_stall_pct;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clip a wide signed value to the accumulator range and note the clip.
  function automatic logic signed [DATA_W-1:0] clip_part(input logic signed [191:0] v,
                                                         inout logic clipped);
    logic signed [191:0] hi_lim;
    logic signed [191:0] lo_lim;
    hi_lim = (192'sd1 <<< (DATA_W - 1)) - 1;
    lo_lim = -(192'sd1 <<< (DATA_W - 1));
    if (v > hi_lim) begin
      clipped = 1'b1;
      return hi_lim[DATA_W-1:0];
    end
    if (v < lo_lim) begin
      clipped = 1'b1;
      return lo_lim[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  // Floor square root, one result bit at a time.
  function automatic logic [DATA_W-1:0] floor_root(input logic [191:0] x);
    logic [191:0] r;
    logic [191:0] c;
    r = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      c = r | (192'd1 << i);
      if (c * c <= x) r = c;
    end
    return r[DATA_W-1:0];
  endfunction

  // Apply one request to the predictor and return the result it implies.
  function automatic rsp_t predict_step(input req_t rq);
    logic signed [191:0] ar, ai, cr, ci, nre, nim, den, qr, qi;
    logic clipped;
    rsp_t rs;
    ar = model_re;
    ai = model_im;
    cr = rq.operand_real;
    ci = rq.operand_imag;
    clipped = 1'b0;
    rs.status = ST_OK;
    case (rq.req_type)
      OP_ADD: begin
        model_re = clip_part(ar + cr, clipped);
        model_im = clip_part(ai + ci, clipped);
      end
      OP_SUB: begin
        model_re = clip_part(ar - cr, clipped);
        model_im = clip_part(ai - ci, clipped);
      end
      OP_MUL: begin
        nre = (ar * cr - ai * ci) >>> FB;
        nim = (ai * cr + ar * ci) >>> FB;
        model_re = clip_part(nre, clipped);
        model_im = clip_part(nim, clipped);
      end
      OP_DIV: begin
        if (cr == 0 && ci == 0) begin
          rs.status = ST_DIVZ;
        end else begin
          den = cr * cr + ci * ci;
          nre = (ar * cr + ai * ci) <<< FB;
          nim = (ai * cr - ar * ci) <<< FB;
          // Signed division in SystemVerilog truncates toward zero.
          qr = nre / den;
          qi = nim / den;
          model_re = clip_part(qr, clipped);
          model_im = clip_part(qi, clipped);
        end
      end
      OP_LOAD: begin
        model_re = rq.operand_real;
        model_im = rq.operand_imag;
      end
      default: begin
      end
    endcase
    if (clipped) rs.status = ST_SAT;
    ar = model_re;
    ai = model_im;
    rs.acc_real_out = model_re;
    rs.acc_imag_out = model_im;
    rs.magnitude = floor_root(ar * ar + ai * ai);
    return rs;
  endfunction

  // Send one request, honoring the sender idle rate, and record its result.
  // Valid stays high after acceptance until the next request or an idle cycle.
  task automatic send_request(input logic [2:0] op, input logic [DATA_W-1:0] re,
                              input logic [DATA_W-1:0] im);
    req_t rq;
    rq.req_type = op;
    rq.operand_real = re;
    rq.operand_imag = im;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp.push_back(predict_step(rq));
  endtask

  // Random operand part, biased toward small values, extremes and full range.
  function automatic logic [DATA_W-1:0] pick_part();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return $signed($urandom_range(8 << FB)) - (4 << FB);
    if (sel == 4) return {1'b0, {(DATA_W-1){1'b1}}};
    if (sel == 5) return {1'b1, {(DATA_W-1){1'b0}}};
    if (sel == 6) return '0;
    return $urandom;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Check each result as it is handed over.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (out_rsp.acc_real_out !== e.acc_real_out) begin
          $error("acc_real_out expected %0h got %0h", e.acc_real_out, out_rsp.acc_real_out);
          errors++;
        end
        if (out_rsp.acc_imag_out !== e.acc_imag_out) begin
          $error("acc_imag_out expected %0h got %0h", e.acc_imag_out, out_rsp.acc_imag_out);
          errors++;
        end
        if (out_rsp.magnitude !== e.magnitude) begin
          $error("magnitude expected %0h got %0h", e.magnitude, out_rsp.magnitude);
          errors++;
        end
        if (out_rsp.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_rsp.status);
          errors++;
        end
      end
    end
  end

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("complex_accumulator_alu_top: mismatch");
      $finish;
    end
  end

  // Directed requests: every operation, the field extremes, saturation,
  // divide by zero and the unused codes.
  task automatic test_directed();
    logic [DATA_W-1:0] pmax;
    logic [DATA_W-1:0] pmin;
    logic [DATA_W-1:0] one;
    pmax = {1'b0, {(DATA_W-1){1'b1}}};
    pmin = {1'b1, {(DATA_W-1){1'b0}}};
    one = 1 << FB;
    send_request(OP_MAG, '0, '0);
    send_request(OP_LOAD, pmax, pmin);
    send_request(OP_MAG, '1, '1);
    send_request(OP_ADD, pmax, pmin);
    send_request(OP_SUB, pmin, pmax);
    send_request(OP_LOAD, one * 3, one * 2);
    send_request(OP_MUL, one, one);
    send_request(OP_MUL, pmax, pmax);
    send_request(OP_LOAD, one * 5, -one * 7);
    send_request(OP_DIV, '0, '0);
    send_request(OP_DIV, one * 2, -one);
    send_request(OP_DIV, 1, 0);
    send_request(OP_LOAD, pmin, pmin);
    send_request(OP_DIV, pmin, pmin);
    send_request(OP_MUL, pmin, pmin);
    send_request(3'd6, pmax, '0);
    send_request(3'd7, '1, pmax);
    send_request(OP_LOAD, 1, 1);
    send_request(OP_SUB, pmax, pmax);
  endtask

  // Random requests: any request code on a loaded accumulator, with the
  // accumulator reloaded often so values stay interesting.
  task automatic test_random(input int count);
    logic [2:0] op;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(5) == 0) op = OP_LOAD;
      else op = 3'($urandom_range(7));
      send_request(op, pick_part(), pick_part());
    end
  endtask

  // The sender holds off until the block has answered everything.
  task automatic test_pause();
    wait_drained();
    repeat (60) @(posedge clk);
    send_request(OP_MAG, '0, '0);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    out_ready <= 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    model_re = '0;
    model_im = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(340);
    sender_idle_pct = 70;
    test_random(340);
    test_pause();
    sender_idle_pct = 0;
    receiver_stall_pct = 70;
    test_random(340);
    sender_idle_pct = 38;
    receiver_stall_pct = 38;
    test_random(340);

    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("complex_accumulator_alu_top: match");
    end else begin
      $display("complex_accumulator_alu_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/cai_pkg.sv
design/cai_iter.sv
design/cai_dp.sv
design/cai_ctrl.sv
design/complex_accumulator_alu_top.sv
bench/tb_complex_accumulator_alu_top.sv
